>>> rtl/conductor_fresnel_reflectance_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the conductor Fresnel reflectance block
// Clocked property checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef CONDUCTOR_FRESNEL_REFLECTANCE_MACROS_SVH
`define CONDUCTOR_FRESNEL_REFLECTANCE_MACROS_SVH

`ifndef ASSERT_OFF
// check a property on an explicit clock and active-low reset
`define CFR_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property on the block clock and reset
`define CFR_ASSERT(lbl, prop, msg) \
    `CFR_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)
`else
`define CFR_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define CFR_ASSERT(lbl, prop, msg)
`endif

`endif

>>> rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the conductor Fresnel reflectance block.
// ----------------------------------------------------------------------------
package cfr_pkg;

    // default fraction bits of the internal fixed-point values
    localparam int CFR_FRAC_BITS = 15;

    // color lanes
    localparam int CFR_NUM_CH = 3;

    // 1.0 in Q1.15
    localparam logic [15:0] CFR_ONE_Q15 = 16'h8000;

    // register reset values, Q4.12
    localparam logic [15:0] CFR_IOR_RESET = 16'h1000;
    localparam logic [15:0] CFR_EXT_RESET = 16'h0000;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_IOR_RED   = 3'd0,
        CFG_IOR_GREEN = 3'd1,
        CFG_IOR_BLUE  = 3'd2,
        CFG_EXT_RED   = 3'd3,
        CFG_EXT_GREEN = 3'd4,
        CFG_EXT_BLUE  = 3'd5
    } t_cfg_idx;

    // pipeline control handed to each color lane
    typedef struct packed {
        logic adv;
        logic vld;
    } t_pipe_ctl;

endpackage

>>> rtl/conductor_fresnel_reflectance.sv
// ----------------------------------------------------------------------------
// conductor_fresnel_reflectance
// Unpolarized conductor Fresnel reflectance for red, green and blue.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                     Payload
// in        slave      i_in_valid / o_in_stall       i_cos_theta (Q1.15)
// out       master     o_out_valid / i_out_stall     o_refl_red/green/blue
// cfg       slave      i_cfg_we                      i_cfg_index, i_cfg_data
//
// One beat is accepted per cycle while the output is not stalled; the lanes are
// built from bit-per-stage square roots and dividers.
// Synchronous active-low reset clears valid bits and loads register defaults.
// A stalled output beat freezes the whole pipeline, and the input stalls.
// ----------------------------------------------------------------------------
`include "conductor_fresnel_reflectance_macros.svh"

module conductor_fresnel_reflectance
    import cfr_pkg::*;
#(
    parameter int FRAC_BITS = CFR_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_cos_theta,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_refl_red,
    output logic [15:0] o_refl_green,
    output logic [15:0] o_refl_blue,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int F    = FRAC_BITS;
    localparam int IN_L = (F >= 15) ? F - 15 : 0;
    localparam int IN_R = (F >= 15) ? 0 : 15 - F;

    // ---------------- configuration registers ----------------
    logic [CFR_NUM_CH-1:0][15:0] r_ior, r_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ior <= {CFR_NUM_CH{CFR_IOR_RESET}};
            r_ext <= {CFR_NUM_CH{CFR_EXT_RESET}};
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IOR_RED:   r_ior[0] <= i_cfg_data;
                CFG_IOR_GREEN: r_ior[1] <= i_cfg_data;
                CFG_IOR_BLUE:  r_ior[2] <= i_cfg_data;
                CFG_EXT_RED:   r_ext[0] <= i_cfg_data;
                CFG_EXT_GREEN: r_ext[1] <= i_cfg_data;
                CFG_EXT_BLUE:  r_ext[2] <= i_cfg_data;
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // ---------------- pipeline advance ----------------
    logic      w_adv;
    logic      w_vld_r, w_vld_g, w_vld_b;
    t_pipe_ctl w_ctl;

    assign w_adv      = ~(w_vld_r & i_out_stall);
    assign o_in_stall = ~w_adv;

    // ---------------- input beat: clamp cosine, move to internal format ----------------
    logic [15:0]  w_cin;
    logic [F+15:0] w_cin_x;
    logic         r_in_vld;
    logic [F:0]   r_c;

    assign w_cin   = (i_cos_theta > CFR_ONE_Q15) ? CFR_ONE_Q15 : i_cos_theta;
    assign w_cin_x = (F+16)'(w_cin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_adv) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c <= (F+1)'((F >= 15) ? (w_cin_x << IN_L) : (w_cin_x >> IN_R));
        end
    end

    assign w_ctl.adv = w_adv;
    assign w_ctl.vld = r_in_vld;

    // ---------------- color lanes ----------------
    cfr_channel #(.FRAC_BITS(FRAC_BITS)) u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_c     (r_c),
        .i_ior   (r_ior[0]),
        .i_ext   (r_ext[0]),
        .o_valid (w_vld_r),
        .o_refl  (o_refl_red)
    );

    cfr_channel #(.FRAC_BITS(FRAC_BITS)) u_green (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_c     (r_c),
        .i_ior   (r_ior[1]),
        .i_ext   (r_ext[1]),
        .o_valid (w_vld_g),
        .o_refl  (o_refl_green)
    );

    cfr_channel #(.FRAC_BITS(FRAC_BITS)) u_blue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_c     (r_c),
        .i_ior   (r_ior[2]),
        .i_ext   (r_ext[2]),
        .o_valid (w_vld_b),
        .o_refl  (o_refl_blue)
    );

    assign o_out_valid = w_vld_r;

    // ---------------- assertions ----------------
    logic w_cfg_drop;

    // flag a write to an index past the last register
    assign w_cfg_drop = i_cfg_we && (i_cfg_index > CFG_EXT_BLUE);

    `CFR_ASSERT(a_lanes_lockstep, (w_vld_r == w_vld_g) && (w_vld_r == w_vld_b), "lanes skewed")
    `CFR_ASSERT(a_red_clamped, o_out_valid |-> (o_refl_red <= CFR_ONE_Q15), "red above one")
    `CFR_ASSERT(a_green_clamped, o_out_valid |-> (o_refl_green <= CFR_ONE_Q15), "green above one")
    `CFR_ASSERT(a_blue_clamped, o_out_valid |-> (o_refl_blue <= CFR_ONE_Q15), "blue above one")
    `CFR_ASSERT(a_cfg_drop, w_cfg_drop |=> $stable({r_ior, r_ext}), "dropped write took effect")

endmodule

>>> rtl/cfr_channel.sv
// ----------------------------------------------------------------------------
// cfr_channel
// One color lane: pipelined unpolarized conductor Fresnel reflectance with
// bit-per-stage square roots and dividers.
// ----------------------------------------------------------------------------
module cfr_channel
    import cfr_pkg::*;
#(
    parameter int FRAC_BITS = CFR_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_pipe_ctl            i_ctl,
    input  logic [FRAC_BITS:0]   i_c,
    input  logic [15:0]          i_ior,
    input  logic [15:0]          i_ext,
    output logic                 o_valid,
    output logic [15:0]          o_refl
);

    localparam int F    = FRAC_BITS;
    localparam int WC   = F + 1;
    localparam int WN   = F + 8;
    localparam int WT0  = F + 10;
    localparam int WMQ  = F + 7;
    localparam int R1   = F + 8;
    localparam int WAB  = F + 10;
    localparam int WS   = F + 12;
    localparam int R2   = F + 5;
    localparam int WT1  = F + 11;
    localparam int WT2  = F + 6;
    localparam int WD   = F + 12;
    localparam int D    = WC;
    localparam int SQ_L = (F >= 24) ? F - 24 : 0;
    localparam int SQ_R = (F >= 24) ? 0 : 24 - F;
    localparam int OUT_L = (F >= 15) ? 0 : 15 - F;
    localparam int OUT_R = (F >= 15) ? F - 15 : 0;
    localparam logic [WC-1:0] ONE = WC'(1) << F;

    typedef struct packed {
        logic                  vld;
        logic [WC-1:0]         c;
        logic [WC-1:0]         cos2;
        logic [WC-1:0]         sin2;
        logic signed [WT0-1:0] t0;
        logic [WAB-1:0]        ab;
    } t_side;

    // ---------------- stage 1: cos^2, n^2, k^2 ----------------
    logic [2*WC-1:0] w_cc;
    logic [31:0]     w_nn, w_kk;
    logic [F+31:0]   w_nn_x, w_kk_x;
    t_side           n_s1, r_s1;
    logic [WN-1:0]   r_s1_n2, r_s1_k2;

    assign w_cc   = (2*WC)'(i_c) * (2*WC)'(i_c);
    assign w_nn   = 32'(i_ior) * 32'(i_ior);
    assign w_kk   = 32'(i_ext) * 32'(i_ext);
    assign w_nn_x = (F+32)'(w_nn);
    assign w_kk_x = (F+32)'(w_kk);

    always_comb begin
        n_s1      = '0;
        n_s1.vld  = i_ctl.vld;
        n_s1.c    = i_c;
        n_s1.cos2 = WC'(w_cc >> F);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (i_ctl.adv) begin
            r_s1 <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_s1_n2 <= WN'((F >= 24) ? (w_nn_x << SQ_L) : (w_nn_x >> SQ_R));
            r_s1_k2 <= WN'((F >= 24) ? (w_kk_x << SQ_L) : (w_kk_x >> SQ_R));
        end
    end

    // ---------------- stage 2: sin^2, t0, |t0|/4 ----------------
    logic [WC-1:0]         w_sin2;
    logic signed [WT0-1:0] w_t0;
    logic [WT0-1:0]        w_mag;
    t_side                 n_s2, r_s2;
    logic [WMQ-1:0]        r_s2_mq;
    logic [WN-1:0]         r_s2_n2, r_s2_k2;

    assign w_sin2 = ONE - r_s1.cos2;
    assign w_t0   = $signed(WT0'(r_s1_n2)) - $signed(WT0'(r_s1_k2)) - $signed(WT0'(w_sin2));
    assign w_mag  = w_t0[WT0-1] ? WT0'(-w_t0) : WT0'(w_t0);

    always_comb begin
        n_s2      = r_s1;
        n_s2.sin2 = w_sin2;
        n_s2.t0   = w_t0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else if (i_ctl.adv) begin
            r_s2 <= n_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_s2_mq <= WMQ'(w_mag >> 2);
            r_s2_n2 <= r_s1_n2;
            r_s2_k2 <= r_s1_k2;
        end
    end

    // ---------------- stage 3: squares for the first root ----------------
    t_side            r_s3;
    logic [2*WMQ-1:0] r_s3_mq2;
    logic [2*WN-1:0]  r_s3_nk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3 <= '0;
        end else if (i_ctl.adv) begin
            r_s3 <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_s3_mq2 <= (2*WMQ)'(r_s2_mq) * (2*WMQ)'(r_s2_mq);
            r_s3_nk  <= (2*WN)'(r_s2_n2) * (2*WN)'(r_s2_k2);
        end
    end

    // ---------------- first square root: ab / 4 ----------------
    t_side             r_q1_side [0:R1];
    logic [R1+1:0]     r_q1_rem  [0:R1-1];
    logic [R1-1:0]     r_q1_root [0:R1];
    logic [2*R1-1:0]   r_q1_rad  [0:R1-1];

    // load the radicand
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_side[0] <= '0;
        end else if (i_ctl.adv) begin
            r_q1_side[0] <= r_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_q1_rad[0]  <= (2*R1)'(r_s3_mq2) + (2*R1)'(r_s3_nk >> 2);
            r_q1_rem[0]  <= '0;
            r_q1_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < R1; k++) begin : g_sq1
        logic [R1+3:0] w_rs, w_tr;
        logic          w_ge;

        assign w_rs = {r_q1_rem[k], r_q1_rad[k][2*R1-1 -: 2]};
        assign w_tr = (R1+4)'({r_q1_root[k], 2'b01});
        assign w_ge = (w_rs >= w_tr);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q1_side[k+1] <= '0;
            end else if (i_ctl.adv) begin
                r_q1_side[k+1] <= r_q1_side[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.adv) begin
                r_q1_root[k+1] <= {r_q1_root[k][R1-2:0], w_ge};
            end
        end

        if (k < R1 - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_ctl.adv) begin
                    r_q1_rem[k+1] <= (R1+2)'(w_ge ? (w_rs - w_tr) : w_rs);
                    r_q1_rad[k+1] <= r_q1_rad[k] << 2;
                end
            end
        end
    end

    // ---------------- stage 5: ab, half sum, second radicand ----------------
    logic [WAB-1:0]        w_ab;
    logic signed [WS-1:0]  w_sum;
    logic [WAB-1:0]        w_half;
    t_side                 n_s5;

    assign w_ab   = {r_q1_root[R1], 2'b00};
    assign w_sum  = $signed(WS'(w_ab)) + WS'(r_q1_side[R1].t0);
    assign w_half = (w_sum > 0) ? WAB'(w_sum >>> 1) : '0;

    always_comb begin
        n_s5    = r_q1_side[R1];
        n_s5.ab = w_ab;
    end

    // ---------------- second square root: a ----------------
    t_side             r_q2_side [0:R2];
    logic [R2+1:0]     r_q2_rem  [0:R2-1];
    logic [R2-1:0]     r_q2_root [0:R2];
    logic [2*R2-1:0]   r_q2_rad  [0:R2-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q2_side[0] <= '0;
        end else if (i_ctl.adv) begin
            r_q2_side[0] <= n_s5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_q2_rad[0]  <= {w_half, F'(0)};
            r_q2_rem[0]  <= '0;
            r_q2_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < R2; k++) begin : g_sq2
        logic [R2+3:0] w_rs, w_tr;
        logic          w_ge;

        assign w_rs = {r_q2_rem[k], r_q2_rad[k][2*R2-1 -: 2]};
        assign w_tr = (R2+4)'({r_q2_root[k], 2'b01});
        assign w_ge = (w_rs >= w_tr);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q2_side[k+1] <= '0;
            end else if (i_ctl.adv) begin
                r_q2_side[k+1] <= r_q2_side[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.adv) begin
                r_q2_root[k+1] <= {r_q2_root[k][R2-2:0], w_ge};
            end
        end

        if (k < R2 - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_ctl.adv) begin
                    r_q2_rem[k+1] <= (R2+2)'(w_ge ? (w_rs - w_tr) : w_rs);
                    r_q2_rad[k+1] <= r_q2_rad[k] << 2;
                end
            end
        end
    end

    // ---------------- stage 6: t1, t2 ----------------
    logic [R2+WC-1:0] w_ac;
    t_side            r_s6;
    logic [WT1-1:0]   r_s6_t1;
    logic [WT2-1:0]   r_s6_t2;

    assign w_ac = (R2+WC)'(r_q2_root[R2]) * (R2+WC)'(r_q2_side[R2].c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6 <= '0;
        end else if (i_ctl.adv) begin
            r_s6 <= r_q2_side[R2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_s6_t1 <= WT1'(r_q2_side[R2].ab) + WT1'(r_q2_side[R2].cos2);
            r_s6_t2 <= WT2'(w_ac >> (F - 1));
        end
    end

    // ---------------- stage 7: rs operands, products for t3 and t4 ----------------
    t_side              r_s7;
    logic [WD-1:0]      r_s7_num_s, r_s7_den_s;
    logic [WC+WAB-1:0]  r_s7_cab;
    logic [2*WC-1:0]    r_s7_ss;
    logic [WT2+WC-1:0]  r_s7_tt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7 <= '0;
        end else if (i_ctl.adv) begin
            r_s7 <= r_s6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_s7_num_s <= (r_s6_t1 > WT1'(r_s6_t2)) ? WD'(r_s6_t1 - WT1'(r_s6_t2)) : '0;
            r_s7_den_s <= WD'(r_s6_t1) + WD'(r_s6_t2);
            r_s7_cab   <= (WC+WAB)'(r_s6.cos2) * (WC+WAB)'(r_s6.ab);
            r_s7_ss    <= (2*WC)'(r_s6.sin2) * (2*WC)'(r_s6.sin2);
            r_s7_tt    <= (WT2+WC)'(r_s6_t2) * (WT2+WC)'(r_s6.sin2);
        end
    end

    // ---------------- stage 8: t3, t4 ----------------
    t_side          r_s8;
    logic [WD-1:0]  r_s8_num_s, r_s8_den_s;
    logic [WT1-1:0] r_s8_t3;
    logic [WT2-1:0] r_s8_t4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8 <= '0;
        end else if (i_ctl.adv) begin
            r_s8 <= r_s7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_s8_num_s <= r_s7_num_s;
            r_s8_den_s <= r_s7_den_s;
            r_s8_t3    <= WT1'((r_s7_cab + (WC+WAB)'(r_s7_ss)) >> F);
            r_s8_t4    <= WT2'(r_s7_tt >> F);
        end
    end

    // ---------------- two dividers in lockstep: rs and rp factor ----------------
    t_side          r_dv_side  [0:D];
    logic [WD:0]    r_dv_rem_s [0:D-1];
    logic [WD:0]    r_dv_rem_p [0:D-1];
    logic [WD-1:0]  r_dv_den_s [0:D];
    logic [WD-1:0]  r_dv_den_p [0:D];
    logic [WC-1:0]  r_dv_quo_s [0:D];
    logic [WC-1:0]  r_dv_quo_p [0:D];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_side[0] <= '0;
        end else if (i_ctl.adv) begin
            r_dv_side[0] <= r_s8;
        end
    end

    // load numerators and denominators
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_dv_rem_s[0] <= (WD+1)'(r_s8_num_s);
            r_dv_den_s[0] <= r_s8_den_s;
            r_dv_rem_p[0] <= (r_s8_t3 > WT1'(r_s8_t4)) ?
                             (WD+1)'(r_s8_t3 - WT1'(r_s8_t4)) : '0;
            r_dv_den_p[0] <= WD'(r_s8_t3) + WD'(r_s8_t4);
            r_dv_quo_s[0] <= '0;
            r_dv_quo_p[0] <= '0;
        end
    end

    for (genvar k = 0; k < D; k++) begin : g_div
        logic          w_ge_s, w_ge_p;
        logic [WD:0]   w_r_s, w_r_p;

        assign w_ge_s = (r_dv_rem_s[k] >= (WD+1)'(r_dv_den_s[k]));
        assign w_ge_p = (r_dv_rem_p[k] >= (WD+1)'(r_dv_den_p[k]));
        assign w_r_s  = w_ge_s ? (r_dv_rem_s[k] - (WD+1)'(r_dv_den_s[k])) : r_dv_rem_s[k];
        assign w_r_p  = w_ge_p ? (r_dv_rem_p[k] - (WD+1)'(r_dv_den_p[k])) : r_dv_rem_p[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_side[k+1] <= '0;
            end else if (i_ctl.adv) begin
                r_dv_side[k+1] <= r_dv_side[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.adv) begin
                r_dv_quo_s[k+1] <= {r_dv_quo_s[k][WC-2:0], w_ge_s};
                r_dv_quo_p[k+1] <= {r_dv_quo_p[k][WC-2:0], w_ge_p};
                r_dv_den_s[k+1] <= r_dv_den_s[k];
                r_dv_den_p[k+1] <= r_dv_den_p[k];
            end
        end

        if (k < D - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_ctl.adv) begin
                    r_dv_rem_s[k+1] <= {w_r_s[WD-1:0], 1'b0};
                    r_dv_rem_p[k+1] <= {w_r_p[WD-1:0], 1'b0};
                end
            end
        end
    end

    // ---------------- stage 10: zero denominators give one ----------------
    logic          r_s10_vld;
    logic [WC-1:0] r_s10_rs, r_s10_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s10_vld <= 1'b0;
        end else if (i_ctl.adv) begin
            r_s10_vld <= r_dv_side[D].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_s10_rs <= (r_dv_den_s[D] == '0) ? ONE : r_dv_quo_s[D];
            r_s10_q  <= (r_dv_den_p[D] == '0) ? ONE : r_dv_quo_p[D];
        end
    end

    // ---------------- stage 11: rp ----------------
    logic            r_s11_vld;
    logic [WC-1:0]   r_s11_rs, r_s11_rp;
    logic [2*WC-1:0] w_rsq;

    assign w_rsq = (2*WC)'(r_s10_rs) * (2*WC)'(r_s10_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s11_vld <= 1'b0;
        end else if (i_ctl.adv) begin
            r_s11_vld <= r_s10_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_s11_rs <= r_s10_rs;
            r_s11_rp <= WC'(w_rsq >> F);
        end
    end

    // ---------------- stage 12: mean, move to Q1.15, clamp ----------------
    logic [WC:0]    w_mean_x;
    logic [WC-1:0]  w_mean;
    logic [WC+15:0] w_wide, w_scaled;
    logic [15:0]    r_s12_refl;
    logic           r_s12_vld;

    assign w_mean_x = (WC+1)'(r_s11_rs) + (WC+1)'(r_s11_rp);
    assign w_mean   = WC'(w_mean_x >> 1);
    assign w_wide   = (WC+16)'(w_mean);
    assign w_scaled = (F >= 15) ? (w_wide >> OUT_R) : (w_wide << OUT_L);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s12_vld <= 1'b0;
        end else if (i_ctl.adv) begin
            r_s12_vld <= r_s11_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_s12_refl <= (w_scaled > (WC+16)'(CFR_ONE_Q15)) ? CFR_ONE_Q15 : w_scaled[15:0];
        end
    end

    assign o_valid = r_s12_vld;
    assign o_refl  = r_s12_refl;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for conductor_fresnel_reflectance
// Streams incidence cosines through the block under several index and
// extinction settings and checks every reflectance beat against an
// in-bench fixed-point predictor, in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import cfr_pkg::*;

    localparam int FB = CFR_FRAC_BITS;
    localparam int LATENCY = 3 * FB + 27;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_refl;

    // floor square root of a 64-bit value
    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // fixed-point ratio, 1.0 on a zero denominator
    function automatic logic [63:0] fx_ratio(logic [63:0] num, logic [63:0] den);
        if (den == 0) return 64'd1 << FB;
        return (num << FB) / den;
    endfunction

    // reflectance of one color lane
    function automatic logic [15:0] lane_refl(logic [63:0] c, logic [15:0] nreg,
                                              logic [15:0] kreg);
        logic [63:0] one, cos2, sin2, n2, k2, mag, mq, ab, half, a;
        logic [63:0] t1, t2, rs, t3, t4, q, rp, r;
        longint t0, sum;
        one  = 64'd1 << FB;
        cos2 = (c * c) >> FB;
        sin2 = one - cos2;
        n2   = (64'(nreg) * 64'(nreg)) >> (24 - FB);
        k2   = (64'(kreg) * 64'(kreg)) >> (24 - FB);
        t0   = longint'(n2) - longint'(k2) - longint'(sin2);
        mag  = (t0 < 0) ? 64'(-t0) : 64'(t0);
        mq   = mag >> 2;
        ab   = isqrt64(mq * mq + ((n2 * k2) >> 2)) << 2;
        sum  = longint'(ab) + t0;
        half = (sum > 0) ? (64'(sum) >> 1) : 64'd0;
        a    = isqrt64(half << FB);
        t1   = ab + cos2;
        t2   = (a * c) >> (FB - 1);
        rs   = fx_ratio((t1 > t2) ? t1 - t2 : 64'd0, t1 + t2);
        t3   = (cos2 * ab + sin2 * sin2) >> FB;
        t4   = (t2 * sin2) >> FB;
        q    = fx_ratio((t3 > t4) ? t3 - t4 : 64'd0, t3 + t4);
        rp   = (rs * q) >> FB;
        r    = ((rs + rp) >> 1) >> (FB - 15);
        return (r > 64'(CFR_ONE_Q15)) ? CFR_ONE_Q15 : r[15:0];
    endfunction

    class refl_scoreboard;
        logic [15:0] ior [CFR_NUM_CH];
        logic [15:0] ext [CFR_NUM_CH];
        t_refl       pending_refl[$];
        int          errors;

        function new();
            foreach (ior[i]) begin
                ior[i] = CFR_IOR_RESET;
                ext[i] = CFR_EXT_RESET;
            end
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] val);
            if (idx <= CFG_IOR_BLUE) ior[idx] = val;
            else ext[idx - CFG_EXT_RED] = val;
        endfunction

        // predict the reflectance of one accepted cosine
        function void note_cosine(logic [15:0] cin);
            logic [63:0] c;
            t_refl e;
            c = (cin > CFR_ONE_Q15) ? 64'(CFR_ONE_Q15) : 64'(cin);
            e.red   = lane_refl(c, ior[0], ext[0]);
            e.green = lane_refl(c, ior[1], ext[1]);
            e.blue  = lane_refl(c, ior[2], ext[2]);
            pending_refl.push_back(e);
        endfunction

        function void check_refl(t_refl got);
            t_refl e;
            if (pending_refl.size() == 0) begin
                $error("unexpected output beat r=%0d g=%0d b=%0d",
                       got.red, got.green, got.blue);
                errors++;
                return;
            end
            e = pending_refl.pop_front();
            if (got.red !== e.red) begin
                $error("refl_red: expected %0d, actual %0d", e.red, got.red);
                errors++;
            end
            if (got.green !== e.green) begin
                $error("refl_green: expected %0d, actual %0d", e.green, got.green);
                errors++;
            end
            if (got.blue !== e.blue) begin
                $error("refl_blue: expected %0d, actual %0d", e.blue, got.blue);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [15:0] cos_theta = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [15:0] refl_red, refl_green, refl_blue;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = 0;
    logic [15:0] cfg_data = 0;

    refl_scoreboard sb = new();
    bit quiet = 0;      // no idling in the last part
    bit hold_off = 0;   // long receiver stall requested
    bit done = 0;
    int idle_cycles = 0;

    conductor_fresnel_reflectance u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_cos_theta  (cos_theta),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_refl_red   (refl_red),
        .o_refl_green (refl_green),
        .o_refl_blue  (refl_blue),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always begin
        #4 clk = 1;
        #4 clk = 0;
    end

    // check output beats and note accepted input beats
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                sb.check_refl('{refl_red, refl_green, refl_blue});
            if (in_valid && !in_stall) sb.note_cosine(cos_theta);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT && !done) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        n = 0;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                out_stall <= 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
                out_stall <= 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 7);
                out_stall <= 1;
                repeat (n) @(posedge clk);
                out_stall <= 0;
            end
        end
    end

    // write one register; the caller drops the write enable after the last one
    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    // offer one cosine beat, with an optional idle burst first
    task automatic send_cosine(logic [15:0] c);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid  <= 1;
        cos_theta <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending_refl.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_cosine();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom_range(32769, 65535));
            1:       return CFR_ONE_Q15;
            2:       return 16'($urandom_range(0, 16));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    initial begin
        t_cfg_idx idx;
        logic [15:0] directed [12];
        directed = '{16'h0000, 16'h0001, 16'h8000, 16'h7fff, 16'h8001,
                     16'hffff, 16'h4000, 16'h5555, 16'haaaa,
                     16'h2d41, 16'h0100, 16'h6000};
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset settings: n = 1, k = 0
        foreach (directed[i]) send_cosine(directed[i]);
        drain();

        // settings: extremes and random; extremes get directed and random cosines, random settings random cosines
        for (int phase = 0; phase < 9; phase++) begin
            for (int r = 0; r < CFR_NUM_CH * 2; r++) begin
                idx = t_cfg_idx'(r);
                case (phase)
                    0: write_reg(idx, 16'h0000);
                    1: write_reg(idx, 16'hffff);
                    2: write_reg(idx, (r < 3) ? 16'hffff : 16'h0000);
                    3: write_reg(idx, (r < 3) ? 16'h0000 : 16'hffff);
                    default: write_reg(idx, 16'($urandom_range(0, 65535)));
                endcase
            end
            cfg_we <= 0;
            if (phase < 4) foreach (directed[i]) send_cosine(directed[i]);
            if (phase == 5) begin
                hold_off = 1;
            end
            if (phase == 8) quiet = 1;
            for (int i = 0; i < 200; i++) send_cosine(rand_cosine());
            drain();
        end

        done = 1;
        repeat (LATENCY) @(posedge clk);
        if (sb.errors == 0 && sb.pending_refl.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
